// ----- rtl/fcfi_pkg.sv -----
// ----------------------------------------------------------------------------
// fcfi_pkg: shared types, widths and helpers for face interpolation
// Q16.16 operand types, divider widths, saturation and truncation helpers.
// ----------------------------------------------------------------------------
package fcfi_pkg;

  localparam int Q_W    = 32;               // Q16.16 word width
  localparam int FRAC_W = 16;               // fraction bits
  localparam int DIV_W  = 34;               // signed divider operand width
  localparam int MAG_W  = DIV_W;            // divider operand magnitude width
  localparam int DVD_W  = MAG_W + FRAC_W;   // scaled dividend width
  localparam int WIDE_W = 66;               // wide intermediate width

  localparam int DIV_LANES_DEF = 1;
  localparam int SIDE_W_DEF    = 1;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [DIV_W-1:0]  div_op_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q_t      Q_MAX  = 32'sh7fff_ffff;
  localparam q_t      Q_MIN  = 32'sh8000_0000;
  localparam div_op_t ONE_OP = 34'sd65536;

  // Clamp a wide signed value to the Q16.16 range.
  function automatic q_t sat_q(input wide_t v);
    q_t r;
    if (v > wide_t'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < wide_t'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Drop the fraction bits, rounding toward zero.
  function automatic wide_t trunc_frac(input wide_t v);
    wide_t r;
    if (v[WIDE_W-1]) begin
      r = (v + wide_t'((1 << FRAC_W) - 1)) >>> FRAC_W;
    end else begin
      r = v >>> FRAC_W;
    end
    return r;
  endfunction

endpackage

// ----- rtl/fcfi_ifs.sv -----
// ----------------------------------------------------------------------------
// fcfi_ifs: valid/ready channels of the face interpolation block
// One channel for face words in, one for interpolated values out.
// ----------------------------------------------------------------------------
interface fcfi_in_if;
  import fcfi_pkg::*;

  logic valid;
  logic ready;
  q_t   face_position;
  q_t   face_velocity;
  q_t   node_pos_a;
  q_t   node_val_a;
  q_t   node_pos_b;
  q_t   node_val_b;
  q_t   node_pos_c;
  q_t   node_val_c;
  q_t   node_pos_d;
  q_t   node_val_d;

  modport source (
    output valid, face_position, face_velocity, node_pos_a, node_val_a,
           node_pos_b, node_val_b, node_pos_c, node_val_c, node_pos_d, node_val_d,
    input  ready
  );
  modport sink (
    input  valid, face_position, face_velocity, node_pos_a, node_val_a,
           node_pos_b, node_val_b, node_pos_c, node_val_c, node_pos_d, node_val_d,
    output ready
  );
endinterface

interface fcfi_out_if;
  import fcfi_pkg::*;

  logic valid;
  logic ready;
  q_t   face_value;

  modport source (output valid, face_value, input ready);
  modport sink   (input valid, face_value, output ready);
endinterface

// ----- rtl/fcfi_div_pipe.sv -----
// ----------------------------------------------------------------------------
// fcfi_div_pipe: pipelined Q16.16 saturating divider, several lanes
// Restoring division, one quotient bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module fcfi_div_pipe #(
  parameter int LANES  = fcfi_pkg::DIV_LANES_DEF,
  parameter int SIDE_W = fcfi_pkg::SIDE_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  fcfi_pkg::div_op_t [LANES-1:0]     num,
  input  fcfi_pkg::div_op_t [LANES-1:0]     den,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output fcfi_pkg::q_t [LANES-1:0]          quo,
  output logic [SIDE_W-1:0]                 out_side
);
  import fcfi_pkg::*;

  localparam int STEPS = Q_W;

  logic [STEPS:0]                 vld_r;
  logic [SIDE_W-1:0]              side_r [0:STEPS];
  logic [LANES-1:0][MAG_W-1:0]    rem_r  [0:STEPS];
  logic [LANES-1:0][MAG_W-1:0]    dmag_r [0:STEPS];
  logic [LANES-1:0][Q_W-1:0]      rq_r   [0:STEPS];
  logic [LANES-1:0]               neg_r  [0:STEPS];
  logic [LANES-1:0]               nz_r   [0:STEPS];
  logic [LANES-1:0]               ovf_r  [0:STEPS];

  logic [LANES-1:0][MAG_W-1:0]    p_nmag;
  logic [LANES-1:0][MAG_W-1:0]    p_dmag;
  logic [LANES-1:0][DVD_W-1:0]    p_dvd;
  logic [LANES-1:0]               p_ovf;

  q_t [LANES-1:0]                 quo_nxt;
  q_t [LANES-1:0]                 quo_r;
  logic                           out_valid_r;
  logic [SIDE_W-1:0]              out_side_r;

  // Prep: magnitudes, result sign, and overflow when quotient needs > 32 bits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_nmag[l] = num[l][DIV_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      p_dmag[l] = den[l][DIV_W-1] ? MAG_W'(-den[l]) : MAG_W'(den[l]);
      p_dvd[l]  = {p_nmag[l], {FRAC_W{1'b0}}};
      p_ovf[l]  = DVD_W'(p_nmag[l]) >= {p_dmag[l], {FRAC_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l]  <= MAG_W'(p_dvd[l][DVD_W-1:Q_W]);
        rq_r[0][l]   <= p_dvd[l][Q_W-1:0];
        dmag_r[0][l] <= p_dmag[l];
        neg_r[0][l]  <= num[l][DIV_W-1] ^ den[l][DIV_W-1];
        nz_r[0][l]   <= (num[l] != '0);
        ovf_r[0][l]  <= p_ovf[l];
      end
    end
  end

  // One quotient bit per stage; rq shifts dividend bits out and quotient in.
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [LANES-1:0][MAG_W:0] trial;
    logic [LANES-1:0][MAG_W:0] diff;
    logic [LANES-1:0]          take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_r[s][l], rq_r[s][l][Q_W-1]};
        diff[l]  = trial[l] - {1'b0, dmag_r[s][l]};
        take[l]  = trial[l] >= {1'b0, dmag_r[s][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= side_r[s];
        for (int l = 0; l < LANES; l++) begin
          rem_r[s+1][l]  <= take[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
          rq_r[s+1][l]   <= {rq_r[s][l][Q_W-2:0], take[l]};
          dmag_r[s+1][l] <= dmag_r[s][l];
          neg_r[s+1][l]  <= neg_r[s][l];
          nz_r[s+1][l]   <= nz_r[s][l];
          ovf_r[s+1][l]  <= ovf_r[s][l];
        end
      end
    end
  end

  // Sign and saturate the quotient.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!nz_r[STEPS][l]) begin
        quo_nxt[l] = '0;
      end else if (!neg_r[STEPS][l]) begin
        quo_nxt[l] = (ovf_r[STEPS][l] || rq_r[STEPS][l][Q_W-1]) ? Q_MAX
                                                                  : q_t'(rq_r[STEPS][l]);
      end else begin
        quo_nxt[l] = (ovf_r[STEPS][l] ||
                      rq_r[STEPS][l] > {1'b1, {(Q_W-1){1'b0}}}) ? Q_MIN
                                                                  : q_t'(-rq_r[STEPS][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r      <= quo_nxt;
      out_side_r <= side_r[STEPS];
    end
  end

  assign out_valid = out_valid_r;
  assign quo       = quo_r;
  assign out_side  = out_side_r;

endmodule

// ----- rtl/fcfi_blend.sv -----
// ----------------------------------------------------------------------------
// fcfi_blend: normalized face value and scale back to physical range
// Two multiplies, truncation and saturation over five register stages.
// ----------------------------------------------------------------------------
module fcfi_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  fcfi_pkg::q_t      t1,
  input  fcfi_pkg::q_t      t2,
  input  fcfi_pkg::q_t      pc,
  input  fcfi_pkg::q_t      vu,
  input  fcfi_pkg::div_op_t dv,
  output logic              out_valid,
  output fcfi_pkg::q_t      face_value
);
  import fcfi_pkg::*;

  logic [4:0]                  vld_r;
  logic signed [2*Q_W-1:0]     prod1_r;
  q_t                          m_r;
  q_t                          pe_r;
  wide_t                       prod2_r;
  q_t                          res_r;
  q_t                          t1_r  [0:1];
  q_t                          vu_r  [0:3];
  div_op_t                     dv_r  [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // multiply t2 by the normalized central value
      prod1_r  <= (2*Q_W)'(t2) * (2*Q_W)'(pc);
      t1_r[0]  <= t1;
      vu_r[0]  <= vu;
      dv_r[0]  <= dv;
      // drop fraction, clamp
      m_r      <= sat_q(trunc_frac(wide_t'(prod1_r)));
      t1_r[1]  <= t1_r[0];
      vu_r[1]  <= vu_r[0];
      dv_r[1]  <= dv_r[0];
      // normalized face value
      pe_r     <= sat_q(wide_t'(t1_r[1]) + wide_t'(m_r));
      vu_r[2]  <= vu_r[1];
      dv_r[2]  <= dv_r[1];
      // scale by the value span
      prod2_r  <= wide_t'(dv_r[2]) * wide_t'(pe_r);
      vu_r[3]  <= vu_r[2];
      // shift back by the upwind value
      res_r    <= sat_q(wide_t'(vu_r[3]) + trunc_frac(prod2_r));
    end
  end

  assign out_valid  = vld_r[4];
  assign face_value = res_r;

endmodule

// ----- rtl/convective_face_interpolation_top.sv -----
// ----------------------------------------------------------------------------
// convective_face_interpolation_top: NVD central-difference face value
// Upwind selection, two pipelined divider banks, blend and scale-back.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    face_position, face_velocity, node_pos/val a..d
//  out_ch    out  valid / ready    face_value
//
//  One word per cycle in and out while the output is not held; a word passes the
//  select stage, the first divider bank, the operand stage, the second divider
//  bank and the blend, in that order, through bit-per-stage dividers.
//  Reset (rst_n low, synchronous) clears only the valid bits of every stage.
//  A held result (out valid, out ready low) freezes every stage and drops
//  in ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module convective_face_interpolation_top (
  input logic        clk,
  input logic        rst_n,
  fcfi_in_if.sink    in_ch,
  fcfi_out_if.source out_ch
);
  import fcfi_pkg::*;

  localparam int SIDE1_W = Q_W + DIV_W;
  localparam int SIDE2_W = 2 * Q_W + DIV_W;

  logic stall;
  logic en;

  // select stage
  logic    upwind_fwd;
  q_t      xu, vu, xc, vc, xw, vw;
  logic    sel_valid_r;
  div_op_t sel_num_r [0:2];
  div_op_t sel_den_r [0:2];
  q_t      sel_vu_r;
  div_op_t sel_dv_r;

  // first divider bank: lane 0 pc, lane 1 nc, lane 2 ne
  div_op_t [2:0]      d1_num, d1_den;
  logic               d1_valid;
  q_t [2:0]           d1_quo;
  logic [SIDE1_W-1:0] d1_side;
  q_t                 d1_vu;
  div_op_t            d1_dv;

  // operand stage for t1 / t2
  logic    mid_valid_r;
  div_op_t mid_num_r [0:1];
  div_op_t mid_den_r [0:1];
  q_t      mid_pc_r;
  q_t      mid_vu_r;
  div_op_t mid_dv_r;

  // second divider bank: lane 0 t1, lane 1 t2
  div_op_t [1:0]      d2_num, d2_den;
  logic               d2_valid;
  q_t [1:0]           d2_quo;
  logic [SIDE2_W-1:0] d2_side;
  q_t                 d2_pc;
  q_t                 d2_vu;
  div_op_t            d2_dv;

  // Hold everything while a finished word waits at the output.
  assign stall       = out_ch.valid && !out_ch.ready;
  assign en          = !stall;
  assign in_ch.ready = en;

  // Pick upwind / central / downwind nodes by velocity sign (zero is forward).
  always_comb begin
    upwind_fwd = (in_ch.face_velocity >= 0);
    if (upwind_fwd) begin
      xu = in_ch.node_pos_a;  vu = in_ch.node_val_a;
      xc = in_ch.node_pos_b;  vc = in_ch.node_val_b;
      xw = in_ch.node_pos_c;  vw = in_ch.node_val_c;
    end else begin
      xu = in_ch.node_pos_d;  vu = in_ch.node_val_d;
      xc = in_ch.node_pos_c;  vc = in_ch.node_val_c;
      xw = in_ch.node_pos_b;  vw = in_ch.node_val_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (en) begin
      sel_valid_r <= in_ch.valid;
    end
  end

  // Exact differences; only the pc divisor gets the one-LSB guard, not the value span.
  always_ff @(posedge clk) begin
    if (en) begin
      sel_num_r[0] <= div_op_t'(vc) - div_op_t'(vu);
      sel_den_r[0] <= div_op_t'(vw) - div_op_t'(vu) + div_op_t'(1);
      sel_num_r[1] <= div_op_t'(xc) - div_op_t'(xu);
      sel_den_r[1] <= div_op_t'(xw) - div_op_t'(xu);
      sel_num_r[2] <= div_op_t'(in_ch.face_position) - div_op_t'(xu);
      sel_den_r[2] <= div_op_t'(xw) - div_op_t'(xu);
      sel_vu_r     <= vu;
      sel_dv_r     <= div_op_t'(vw) - div_op_t'(vu);
    end
  end

  assign d1_num = {sel_num_r[2], sel_num_r[1], sel_num_r[0]};
  assign d1_den = {sel_den_r[2], sel_den_r[1], sel_den_r[0]};

  fcfi_div_pipe #(
    .LANES  (3),
    .SIDE_W (SIDE1_W)
  ) u_div_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sel_valid_r),
    .num       (d1_num),
    .den       (d1_den),
    .in_side   ({sel_vu_r, sel_dv_r}),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .out_side  (d1_side)
  );

  assign d1_vu = d1_side[SIDE1_W-1:DIV_W];
  assign d1_dv = d1_side[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (en) begin
      mid_valid_r <= d1_valid;
    end
  end

  // t1 = (ne - nc) / (1 - nc), t2 = (ne - 1) / (nc - 1)
  always_ff @(posedge clk) begin
    if (en) begin
      mid_num_r[0] <= div_op_t'(d1_quo[2]) - div_op_t'(d1_quo[1]);
      mid_den_r[0] <= ONE_OP - div_op_t'(d1_quo[1]);
      mid_num_r[1] <= div_op_t'(d1_quo[2]) - ONE_OP;
      mid_den_r[1] <= div_op_t'(d1_quo[1]) - ONE_OP;
      mid_pc_r     <= d1_quo[0];
      mid_vu_r     <= d1_vu;
      mid_dv_r     <= d1_dv;
    end
  end

  assign d2_num = {mid_num_r[1], mid_num_r[0]};
  assign d2_den = {mid_den_r[1], mid_den_r[0]};

  fcfi_div_pipe #(
    .LANES  (2),
    .SIDE_W (SIDE2_W)
  ) u_div_slope (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mid_valid_r),
    .num       (d2_num),
    .den       (d2_den),
    .in_side   ({mid_pc_r, mid_vu_r, mid_dv_r}),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .out_side  (d2_side)
  );

  assign d2_pc = d2_side[SIDE2_W-1:Q_W+DIV_W];
  assign d2_vu = d2_side[Q_W+DIV_W-1:DIV_W];
  assign d2_dv = d2_side[DIV_W-1:0];

  // Blend and scale back; its last register is the output register.
  fcfi_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d2_valid),
    .t1         (d2_quo[0]),
    .t2         (d2_quo[1]),
    .pc         (d2_pc),
    .vu         (d2_vu),
    .dv         (d2_dv),
    .out_valid  (out_ch.valid),
    .face_value (out_ch.face_value)
  );

  // An accepted word shows up in the select stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> sel_valid_r)
    else $error("accepted face word missing from select stage");

  // A held output freezes the inner stages.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(sel_valid_r) && $stable(mid_valid_r) && $stable(d2_valid))
    else $error("pipeline moved during output stall");

  // A valid from the first divider bank, taken on an enabled cycle, is registered into the operand stage.
  a_mid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en && d1_valid |=> mid_valid_r)
    else $error("first divider result lost before operand stage");

endmodule

// ----- dv/tb_convective_face_interpolation_top.sv -----
// ----------------------------------------------------------------------------
// tb_convective_face_interpolation_top: face interpolation block testbench
// Drives face words through the valid/ready channels under random idling,
// predicts each interpolated value in a scoreboard and checks it in order.
// ----------------------------------------------------------------------------
module tb_convective_face_interpolation_top;
  import fcfi_pkg::*;

  localparam int LATENCY     = 75;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 900;

  // One face as it enters the block.
  typedef struct packed {
    q_t face_position;
    q_t face_velocity;
    q_t pos_a;
    q_t val_a;
    q_t pos_b;
    q_t val_b;
    q_t pos_c;
    q_t val_c;
    q_t pos_d;
    q_t val_d;
  } face_word_t;

  // Predict face values and hold them until the block delivers them.
  class face_value_scoreboard;
    q_t pending_values[$];
    int error_count;

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Saturating Q16.16 divide; a zero divisor picks the rail of the numerator, or zero for a zero numerator.
    function longint qdiv(longint n, longint d);
      if (d == 0) begin
        if (n > 0) return 64'sd2147483647;
        if (n < 0) return -64'sd2147483648;
        return 0;
      end
      return sat((n * 65536) / d);
    endfunction

    function q_t interpolate(face_word_t f);
      longint xu, vu, xc, vc, xw, vw, xf;
      longint pc, nc, ne, t1, t2, m, pe;
      xf = f.face_position;
      if (f.face_velocity >= 0) begin
        xu = f.pos_a; vu = f.val_a; xc = f.pos_b; vc = f.val_b;
        xw = f.pos_c; vw = f.val_c;
      end else begin
        xu = f.pos_d; vu = f.val_d; xc = f.pos_c; vc = f.val_c;
        xw = f.pos_b; vw = f.val_b;
      end
      pc = qdiv(vc - vu, vw - vu + 1);
      nc = qdiv(xc - xu, xw - xu);
      ne = qdiv(xf - xu, xw - xu);
      t1 = qdiv(ne - nc, 65536 - nc);
      t2 = qdiv(ne - 65536, nc - 65536);
      m  = sat((t2 * pc) / 65536);
      pe = sat(t1 + m);
      return q_t'(sat(vu + ((vw - vu) * pe) / 65536));
    endfunction

    function void note_face(face_word_t f);
      pending_values.push_back(interpolate(f));
    endfunction

    task check_value(q_t got);
      q_t want;
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("face value %h with nothing expected", got));
        return;
      end
      want = pending_values.pop_front();
      if (got !== want)
        report_mismatch($sformatf("face_value got %h expected %h", got, want));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  fcfi_in_if  in_ch();
  fcfi_out_if out_ch();

  face_value_scoreboard faces;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_receiver;
  longint cycle_count = 0;

  convective_face_interpolation_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Bail out on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every accepted result word; randomly stall the receiver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        faces.check_value(out_ch.face_value);
      out_ch.ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // Pick a value that hits rails and small numbers often.
  function automatic q_t pick_q();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return q_t'(0);
      3: return q_t'($urandom_range(8) * 32'sd65536 - 32'sd262144);
      4, 5: return q_t'($signed($urandom_range(65536 * 40)) - 32'sd1310720);
      default: return q_t'($urandom);
    endcase
  endfunction

  // Mostly well-ordered nodes with the face between b and c; sometimes noise.
  function automatic face_word_t random_face();
    face_word_t f;
    int base, step;
    if ($urandom_range(3) != 0) begin
      base = $signed($urandom_range(2000000)) - 1000000;
      step = $urandom_range(400000) + 1;
      f.pos_a = base;
      f.pos_b = base + step;
      f.pos_c = base + 2 * step + $urandom_range(1000);
      f.pos_d = f.pos_c + step;
      f.face_position = f.pos_b + $urandom_range(step);
      f.val_a = $signed($urandom_range(2000000)) - 1000000;
      f.val_b = $signed($urandom_range(2000000)) - 1000000;
      f.val_c = $signed($urandom_range(2000000)) - 1000000;
      f.val_d = $signed($urandom_range(2000000)) - 1000000;
      f.face_velocity = $urandom;
    end else begin
      f = {pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
           pick_q(), pick_q(), pick_q(), pick_q(), pick_q()};
    end
    return f;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_face(face_word_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.face_position <= f.face_position;
    in_ch.face_velocity <= f.face_velocity;
    in_ch.node_pos_a    <= f.pos_a;
    in_ch.node_val_a    <= f.val_a;
    in_ch.node_pos_b    <= f.pos_b;
    in_ch.node_val_b    <= f.val_b;
    in_ch.node_pos_c    <= f.pos_c;
    in_ch.node_val_c    <= f.val_c;
    in_ch.node_pos_d    <= f.pos_d;
    in_ch.node_val_d    <= f.val_d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    faces.note_face(f);
  endtask

  task automatic drain_results();
    while (faces.pending_values.size() != 0) @(posedge clk);
  endtask

  // Directed faces: rails, zero velocity, both directions, zero divisors.
  task automatic send_directed();
    face_word_t f;
    f = '0;
    send_face(f);
    f = {Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
    send_face(f);
    f = {Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
    send_face(f);
    // Regular mesh, zero velocity then negative velocity.
    f = {32'sh0001_8000, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0001_0000,
         32'sh0002_0000, 32'sh0002_0000, 32'sh0005_0000, 32'sh0003_0000,
         32'sh0003_0000};
    send_face(f);
    f.face_velocity = -32'sd1;
    send_face(f);
    f.face_velocity = Q_MIN;
    send_face(f);
    // Value difference of minus one LSB: guarded divisor is zero.
    f.face_velocity = 32'sd5;
    f.val_c = f.val_a - 1;
    send_face(f);
    // Coincident upwind and downwind positions.
    f.pos_c = f.pos_a;
    send_face(f);
    // Central point at normalized one.
    f.pos_c = 32'sh0002_0000;
    f.pos_b = f.pos_c;
    send_face(f);
    // Mixed rails to push every saturation.
    f = {Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN};
    send_face(f);
    f = {Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX};
    send_face(f);
    f = {32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd1, Q_MAX, 32'sd2, Q_MIN, 32'sd3,
         32'sd7};
    send_face(f);
    f = {32'shffff_ffff, 32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa,
         32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
         32'shaaaa_aaaa, 32'sh5555_5555};
    send_face(f);
  endtask

  task automatic send_random(int count);
    repeat (count) send_face(random_face());
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    faces = new();
    hold_receiver = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 80;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.face_position = '0;
    in_ch.face_velocity = '0;
    in_ch.node_pos_a = '0;
    in_ch.node_val_a = '0;
    in_ch.node_pos_b = '0;
    in_ch.node_val_b = '0;
    in_ch.node_pos_c = '0;
    in_ch.node_val_c = '0;
    in_ch.node_pos_d = '0;
    in_ch.node_val_d = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    send_random(N_RANDOM / 3);

    // Pause the sender until the pipe is empty.
    in_ch.valid <= 1'b0;
    drain_results();

    // Hold the receiver long enough to fill the pipe and stall the input.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      send_random(150);
    join

    send_idle_pct = 80;
    recv_idle_pct = 11;
    send_random(N_RANDOM / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(N_RANDOM / 3 - 150);

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (faces.error_count == 0 && faces.pending_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/fcfi_pkg.sv
rtl/fcfi_ifs.sv
rtl/fcfi_div_pipe.sv
rtl/fcfi_blend.sv
rtl/convective_face_interpolation_top.sv
dv/tb_convective_face_interpolation_top.sv
